### design/flp_pkg.sv
// Shared types, coefficients and helpers for the s15.16 log2/exp2/pow unit.
package flp_pkg;

    // Operation selectors
    localparam logic [1:0] OP_LOG2 = 2'd0;
    localparam logic [1:0] OP_EXP2 = 2'd1;
    localparam logic [1:0] OP_POW  = 2'd2;
    localparam logic [1:0] OP_MUL  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DOMAIN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Round-half-up of mant/scale in 0.32 format, worked out at elaboration
    localparam logic [31:0] LG_C0 = 32'((128'd44269476063 * (128'd1 << 33)
        + 128'd100000000000) / 128'd200000000000);
    localparam logic [31:0] LG_C1 = 32'((128'd72131008654833 * (128'd1 << 33)
        + 128'd100000000000000) / 128'd200000000000000);
    localparam logic [31:0] LG_C2 = 32'((128'd48006370104849 * (128'd1 << 33)
        + 128'd100000000000000) / 128'd200000000000000);
    localparam logic [31:0] LG_C3 = 32'((128'd35339481476694 * (128'd1 << 33)
        + 128'd100000000000000) / 128'd200000000000000);
    localparam logic [31:0] LG_C4 = 32'((128'd25600972794928 * (128'd1 << 33)
        + 128'd100000000000000) / 128'd200000000000000);
    localparam logic [31:0] LG_C5 = 32'((128'd15535182948224 * (128'd1 << 33)
        + 128'd100000000000000) / 128'd200000000000000);
    localparam logic [31:0] LG_C6 = 32'((128'd63607925549150 * (128'd1 << 33)
        + 128'd1000000000000000) / 128'd2000000000000000);
    localparam logic [31:0] LG_C7 = 32'((128'd12319647939876 * (128'd1 << 33)
        + 128'd1000000000000000) / 128'd2000000000000000);

    localparam logic [31:0] EX_C0 = 32'((128'd69314718107 * (128'd1 << 33)
        + 128'd100000000000) / 128'd200000000000);
    localparam logic [31:0] EX_C1 = 32'((128'd24022648809 * (128'd1 << 33)
        + 128'd100000000000) / 128'd200000000000);
    localparam logic [31:0] EX_C2 = 32'((128'd55504413787 * (128'd1 << 33)
        + 128'd1000000000000) / 128'd2000000000000);
    localparam logic [31:0] EX_C3 = 32'((128'd96162736882 * (128'd1 << 33)
        + 128'd10000000000000) / 128'd20000000000000);
    localparam logic [31:0] EX_C4 = 32'((128'd13386828359 * (128'd1 << 33)
        + 128'd10000000000000) / 128'd20000000000000);
    localparam logic [31:0] EX_C5 = 32'((128'd14629773796 * (128'd1 << 33)
        + 128'd100000000000000) / 128'd200000000000000);
    localparam logic [31:0] EX_C6 = 32'((128'd20663021132 * (128'd1 << 33)
        + 128'd1000000000000000) / 128'd2000000000000000);

    // One request as it enters
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_item;

    // Upper word of an unsigned 32x32 product
    function automatic logic [31:0] mulhi(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, y};
        return p[63:32];
    endfunction

    // Leading zero count, capped at 31
    function automatic logic [4:0] clz31(input logic [31:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd31;
        hit = 1'b0;
        for (int k = 31; k >= 1; k--) begin
            if (!hit && v[k]) begin
                n   = 5'(31 - k);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### design/flp_log2_pipe.sv
// Six-stage log2 front end: normalize, degree-8 polynomial, round to s15.16.
module flp_log2_pipe
    import flp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_item       i_item,
    output logic        o_vld,
    output t_item       o_item,
    output logic        o_apos,
    output logic [31:0] o_lg
);

    localparam int Depth = 6;

    typedef struct packed {
        t_item       itm;
        logic        apos;
        logic [4:0]  lz;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] t1;
        logic [31:0] t3;
        logic [31:0] t5;
        logic [31:0] t7;
        logic [31:0] h;
        logic [31:0] m;
        logic [31:0] u;
        logic [31:0] l;
        logic [31:0] ap;
        logic [31:0] lg;
    } t_lgs;

    t_lgs             r_stg [Depth];
    t_lgs             n_stg [Depth];
    logic [Depth-1:0] r_vld;

    // Stage datapath
    always_comb begin
        logic [4:0] lz;
        n_stg[0] = r_stg[0];
        for (int k = 1; k < Depth; k++) begin
            n_stg[k] = r_stg[k-1];
        end
        // normalize
        lz = clz31(i_item.a);
        n_stg[0].itm  = i_item;
        n_stg[0].apos = (i_item.a != 32'd0) && !i_item.a[31];
        n_stg[0].lz   = lz;
        n_stg[0].x    = (lz == 5'd31) ? 32'd0 : (i_item.a << (lz + 5'd1));
        // square and odd terms
        n_stg[1].y  = mulhi(r_stg[0].x, r_stg[0].x);
        n_stg[1].t1 = mulhi(LG_C1, r_stg[0].x);
        n_stg[1].t3 = mulhi(LG_C3, r_stg[0].x);
        n_stg[1].t5 = mulhi(LG_C5, r_stg[0].x);
        n_stg[1].t7 = mulhi(LG_C7, r_stg[0].x);
        // fourth power and pair terms
        n_stg[2].z = mulhi(r_stg[1].y, r_stg[1].y);
        n_stg[2].m = mulhi(LG_C2 - r_stg[1].t3, r_stg[1].y);
        n_stg[2].u = mulhi(LG_C6 - r_stg[1].t7, r_stg[1].y);
        n_stg[2].h = LG_C0 - r_stg[1].t1;
        // high group
        n_stg[3].l = mulhi(LG_C4 - r_stg[2].t5 + r_stg[2].u, r_stg[2].z);
        // polynomial times x
        n_stg[4].ap = r_stg[3].x
                    + mulhi(r_stg[3].x, r_stg[3].h + r_stg[3].m + r_stg[3].l);
        // exponent and rounding
        n_stg[5].lg = {16'(16'd15 - {11'd0, r_stg[4].lz}), 16'd0}
                    + {15'd0, 17'((({1'b0, r_stg[4].ap[31:15]}) + 18'd1) >> 1)};
    end

    // Advance the data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Depth; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Depth-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[Depth-1];
    assign o_item = r_stg[Depth-1].itm;
    assign o_apos = r_stg[Depth-1].apos;
    assign o_lg   = r_stg[Depth-1].lg;

endmodule

### design/fixed_log2_exp2_pow_unit.sv
// s15.16 log2 / exp2 / pow / rounded multiply unit, thirteen-stage pipeline.
// Every request passes through the same thirteen register stages (six for
// log2, one for the signed product, six for exp2), and one request can
// enter per cycle unless the output stalls. The pipeline advances as a
// whole whenever the output register is empty or being drained; a stall
// holds every stage. Latency is set by the chain of dependent 32x32
// multiplies in the two polynomials.
module fixed_log2_exp2_pow_unit
    import flp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] arg_a, [63:32] arg_b
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] result
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int Depth = 7;

    typedef struct packed {
        t_item              itm;
        logic               apos;
        logic [31:0]        lg;
        logic signed [63:0] prod;
        logic [31:0]        mres;
        logic signed [15:0] ei;
        logic [31:0]        f;
        logic [31:0]        s;
        logic [31:0]        q;
        logic [31:0]        t1;
        logic [31:0]        t3;
        logic [31:0]        t5;
        logic [31:0]        h;
        logic [31:0]        m;
        logic [31:0]        w;
        logic [31:0]        l;
        logic [31:0]        ap;
        logic [31:0]        res;
        logic [1:0]         st;
    } t_exs;

    logic             en;
    t_item            in_item;
    logic             lg_vld;
    t_item            lg_item;
    logic             lg_apos;
    logic [31:0]      lg_val;
    t_exs             r_stg [Depth];
    t_exs             n_stg [Depth];
    logic [Depth-1:0] r_vld;

    assign en         = !r_vld[Depth-1] || i_m_tready;
    assign o_s_tready = en;
    assign in_item    = '{op: i_s_tuser, a: i_s_tdata[31:0], b: i_s_tdata[63:32]};

    flp_log2_pipe u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_item  (in_item),
        .o_vld   (lg_vld),
        .o_item  (lg_item),
        .o_apos  (lg_apos),
        .o_lg    (lg_val)
    );

    // Stage datapath
    always_comb begin
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] rnd;
        logic [31:0] eop;
        logic [4:0]  sh1;
        logic [4:0]  sh2;
        logic [32:0] sum;
        logic [31:0] ex_res;
        logic [1:0]  ex_st;
        n_stg[0] = r_stg[0];
        for (int k = 1; k < Depth; k++) begin
            n_stg[k] = r_stg[k-1];
        end
        // signed product: b*log2(a) for pow, a*b for multiply
        ma = (lg_item.op == OP_MUL) ? lg_item.a : lg_item.b;
        mb = (lg_item.op == OP_MUL) ? lg_item.b : lg_val;
        n_stg[0].itm  = lg_item;
        n_stg[0].apos = lg_apos;
        n_stg[0].lg   = lg_val;
        n_stg[0].prod = $signed(ma) * $signed(mb);
        // round product and split exp2 operand
        rnd = 64'(r_stg[0].prod) + 64'h8000;
        n_stg[1].mres = rnd[47:16];
        eop = (r_stg[0].itm.op == OP_EXP2) ? r_stg[0].itm.a : rnd[47:16];
        n_stg[1].ei = $signed(eop[31:16]);
        n_stg[1].f  = {eop[15:0], 16'd0};
        // square and odd terms
        n_stg[2].s  = mulhi(r_stg[1].f, r_stg[1].f);
        n_stg[2].t1 = mulhi(EX_C1, r_stg[1].f);
        n_stg[2].t3 = mulhi(EX_C3, r_stg[1].f);
        n_stg[2].t5 = mulhi(EX_C5, r_stg[1].f);
        // fourth power and pair terms
        n_stg[3].q = mulhi(r_stg[2].s, r_stg[2].s);
        n_stg[3].m = mulhi(EX_C2 + r_stg[2].t3, r_stg[2].s);
        n_stg[3].w = mulhi(EX_C6, r_stg[2].s);
        n_stg[3].h = EX_C0 + r_stg[2].t1;
        // high group
        n_stg[4].l = mulhi(EX_C4 + r_stg[3].t5 + r_stg[3].w, r_stg[3].q);
        // polynomial times f
        n_stg[5].ap = mulhi(r_stg[4].f, r_stg[4].h + r_stg[4].m + r_stg[4].l);
        // shift by the integer part, round, saturate, pick the result
        sh1 = 5'(16'sd15 - r_stg[5].ei);
        sh2 = 5'(16'sd14 - r_stg[5].ei);
        sum = {1'b0, r_stg[5].ap >> sh1} + {1'b0, 32'h8000_0000 >> sh2} + 33'd1;
        if (r_stg[5].ei >= 16'sd15) begin
            ex_res = 32'h7fff_ffff;
            ex_st  = ST_OVERFLOW;
        end else if (r_stg[5].ei < -16'sd16) begin
            ex_res = 32'd0;
            ex_st  = ST_OK;
        end else if (sum[32]) begin
            ex_res = 32'h7fff_ffff;
            ex_st  = ST_OVERFLOW;
        end else begin
            ex_res = sum[32:1];
            ex_st  = ST_OK;
        end
        case (r_stg[5].itm.op)
            OP_LOG2: begin
                n_stg[6].res = r_stg[5].apos ? r_stg[5].lg : 32'h8000_0000;
                n_stg[6].st  = r_stg[5].apos ? ST_OK : ST_DOMAIN;
            end
            OP_EXP2: begin
                n_stg[6].res = ex_res;
                n_stg[6].st  = ex_st;
            end
            OP_POW: begin
                n_stg[6].res = r_stg[5].apos ? ex_res : 32'd0;
                n_stg[6].st  = r_stg[5].apos ? ex_st : ST_DOMAIN;
            end
            default: begin
                n_stg[6].res = r_stg[5].mres;
                n_stg[6].st  = ST_OK;
            end
        endcase
    end

    // Advance the data
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < Depth; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], lg_vld};
        end
    end

    assign o_m_tvalid = r_vld[Depth-1];
    assign o_m_tdata  = r_stg[Depth-1].res;
    assign o_m_tuser  = r_stg[Depth-1].st;

endmodule

### design/flp_checker.sv
// Port-level checks for the log2/exp2/pow unit, bound to the top level.
module flp_checker
    import flp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Take requests while the output is empty
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("request refused with empty output");

    // Domain status comes only with its fixed results
    a_domain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_DOMAIN |->
        o_m_tdata == 32'h8000_0000 || o_m_tdata == 32'd0)
        else $error("domain status with wrong result");

    // Overflow status always saturates
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_OVERFLOW |-> o_m_tdata == 32'h7fff_ffff)
        else $error("overflow status without saturation");

endmodule

bind fixed_log2_exp2_pow_unit flp_checker u_flp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### verif/testbench.sv
// Self-checking testbench for the s15.16 log2/exp2/pow/multiply unit.
`timescale 1ns / 100ps

module testbench;
    import flp_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_req;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        s_tready;
    logic [63:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_req  pending_reqs[$];
    t_res  expected_results[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    mismatches;
    bit    stim_done;

    fixed_log2_exp2_pow_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // round(mant/scale * 2^32), long division one byte at a time
    function automatic logic [31:0] q32_coef(input logic [63:0] mant, input logic [63:0] scale);
        logic [63:0] q;
        logic [63:0] r;
        q = 0;
        r = mant % scale;
        for (int k = 0; k < 4; k++) begin
            r = r << 8;
            q = (q << 8) | (r / scale);
            r = r % scale;
        end
        if (2 * r >= scale) q = q + 1;
        return q[31:0];
    endfunction

    function automatic logic [31:0] hi_mul(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, y};
        return p[63:32];
    endfunction

    // rounded signed s15.16 product, wrapped to 32 bits
    function automatic logic [31:0] fix_mul(input logic [31:0] x, input logic [31:0] y);
        logic signed [63:0] t;
        logic [63:0]        u;
        t = $signed({{32{x[31]}}, x}) * $signed({{32{y[31]}}, y});
        u = 64'(t) + 64'h8000;
        return u[47:16];
    endfunction

    function automatic logic [31:0] fix_log2(input logic [31:0] a);
        logic [31:0] c[8];
        logic [31:0] x, y, z, h, m, l, approx;
        int          lz;
        c[0] = q32_coef(64'd44269476063, 64'd100000000000);
        c[1] = q32_coef(64'd72131008654833, 64'd100000000000000);
        c[2] = q32_coef(64'd48006370104849, 64'd100000000000000);
        c[3] = q32_coef(64'd35339481476694, 64'd100000000000000);
        c[4] = q32_coef(64'd25600972794928, 64'd100000000000000);
        c[5] = q32_coef(64'd15535182948224, 64'd100000000000000);
        c[6] = q32_coef(64'd63607925549150, 64'd1000000000000000);
        c[7] = q32_coef(64'd12319647939876, 64'd1000000000000000);
        lz = 0;
        while (lz < 31 && !a[31 - lz]) lz++;
        x = (lz >= 31) ? 32'd0 : (a << (lz + 1));
        y = hi_mul(x, x);
        z = hi_mul(y, y);
        h = c[0] - hi_mul(c[1], x);
        m = hi_mul(c[2] - hi_mul(c[3], x), y);
        l = hi_mul(c[4] - hi_mul(c[5], x) + hi_mul(c[6] - hi_mul(c[7], x), y), z);
        approx = x + hi_mul(x, h + m + l);
        return (32'(15 - lz) << 16) + (((approx >> 15) + 32'd1) >> 1);
    endfunction

    function automatic t_res fix_exp2(input logic [31:0] a);
        logic [31:0] c[7];
        logic [31:0] f, s, q, h, m, l, approx;
        logic [63:0] sum;
        int          ip;
        t_res        r;
        ip = $signed(a[31:16]);
        r.status = ST_OK;
        if (ip >= 15) begin
            r.value  = 32'h7fffffff;
            r.status = ST_OVERFLOW;
            return r;
        end
        if (ip < -16) begin
            r.value = 0;
            return r;
        end
        c[0] = q32_coef(64'd69314718107, 64'd100000000000);
        c[1] = q32_coef(64'd24022648809, 64'd100000000000);
        c[2] = q32_coef(64'd55504413787, 64'd1000000000000);
        c[3] = q32_coef(64'd96162736882, 64'd10000000000000);
        c[4] = q32_coef(64'd13386828359, 64'd10000000000000);
        c[5] = q32_coef(64'd14629773796, 64'd100000000000000);
        c[6] = q32_coef(64'd20663021132, 64'd1000000000000000);
        f = a << 16;
        s = hi_mul(f, f);
        q = hi_mul(s, s);
        h = c[0] + hi_mul(c[1], f);
        m = hi_mul(c[2] + hi_mul(c[3], f), s);
        l = hi_mul(c[4] + hi_mul(c[5], f) + hi_mul(c[6], s), q);
        approx = hi_mul(f, h + m + l);
        sum = ({32'd0, approx >> (15 - ip)} + {32'd0, 32'h80000000 >> (14 - ip)} + 64'd1) >> 1;
        if (sum > 64'h7fffffff) begin
            r.value  = 32'h7fffffff;
            r.status = ST_OVERFLOW;
        end else begin
            r.value = sum[31:0];
        end
        return r;
    endfunction

    function automatic t_res compute_result(input t_req rq);
        t_res r;
        logic a_pos;
        a_pos = (rq.a != 0) && !rq.a[31];
        r.status = ST_OK;
        case (rq.op)
            OP_LOG2: begin
                if (a_pos) r.value = fix_log2(rq.a);
                else begin
                    r.value  = 32'h80000000;
                    r.status = ST_DOMAIN;
                end
            end
            OP_EXP2: r = fix_exp2(rq.a);
            OP_POW: begin
                if (a_pos) r = fix_exp2(fix_mul(rq.b, fix_log2(rq.a)));
                else begin
                    r.value  = 0;
                    r.status = ST_DOMAIN;
                end
            end
            default: r.value = fix_mul(rq.a, rq.b);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000fffff);
            2: return 32'($signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000);
            3: return $urandom_range(1, 32'h00300000);
            4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)} ^ 32'h0;
            default: return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
        endcase
    endfunction

    task automatic add_req(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
        t_req rq;
        rq.op = op;
        rq.a  = a;
        rq.b  = b;
        pending_reqs.push_back(rq);
    endtask

    // Drive requests; predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && s_tready) begin
                expected_results.push_back(compute_result({i_s_tuser, i_s_tdata[31:0],
                    i_s_tdata[63:32]}));
                void'(pending_reqs.pop_front());
            end
            if (!i_s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= pending_reqs[0].op;
                    i_s_tdata  <= {pending_reqs[0].b, pending_reqs[0].a};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check results in order; stall the receiver at random
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h status %0d", o_m_tdata, o_m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata !== want.value || o_m_tuser !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%0d, got %h/%0d",
                                want.value, want.status, o_m_tdata, o_m_tuser);
                    end
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_LOG2;
        i_m_tready     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        stim_done      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: domain edges, log of one and raw one, exp2 limits, wrap
        add_req(OP_LOG2, 32'h00000000, 32'h0);
        add_req(OP_LOG2, 32'h80000000, 32'hffffffff);
        add_req(OP_LOG2, 32'hffffffff, 32'h0);
        add_req(OP_LOG2, 32'h00000001, 32'h0);
        add_req(OP_LOG2, 32'h00010000, 32'h0);
        add_req(OP_LOG2, 32'h7fffffff, 32'h0);
        add_req(OP_EXP2, 32'h000f0000, 32'h0);
        add_req(OP_EXP2, 32'h000effff, 32'h0);
        add_req(OP_EXP2, 32'h7fffffff, 32'h0);
        add_req(OP_EXP2, 32'hfff00000, 32'h0);
        add_req(OP_EXP2, 32'hffefffff, 32'h0);
        add_req(OP_EXP2, 32'h80000000, 32'h0);
        add_req(OP_EXP2, 32'h00000000, 32'hffffffff);
        add_req(OP_POW, 32'h00000000, 32'h00020000);
        add_req(OP_POW, 32'hffff0000, 32'h00020000);
        add_req(OP_POW, 32'h00020000, 32'h00100000);
        add_req(OP_POW, 32'h00020000, 32'h00030000);
        add_req(OP_POW, 32'h7fffffff, 32'h80000000);
        add_req(OP_MUL, 32'h7fffffff, 32'h7fffffff);
        add_req(OP_MUL, 32'h80000000, 32'h80000000);
        add_req(OP_MUL, 32'hffffffff, 32'h00008000);
        add_req(OP_MUL, 32'h00018000, 32'hfffe8000);

        // random, in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 440; n++)
                add_req(2'($urandom_range(0, 3)), rand_word(), rand_word());
            while (pending_reqs.size() != 0) @(posedge i_clk);
            case (ph)
                0: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                1: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (expected_results.size() != 0 || i_s_tvalid) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
